[src/fmcq_pkg.sv]
// ----------------------------------------------------------------------------
// fmcq_pkg: shared types and constants for the frame metadata capture queue
// Entry layout, request and status codes, and the per-request action record.
// ----------------------------------------------------------------------------
package fmcq_pkg;

   // request selector carried in req_tuser
   localparam logic REQ_RX  = 1'b0;
   localparam logic REQ_POP = 1'b1;

   // frame event status codes
   localparam logic [1:0] RX_STORED  = 2'd0;
   localparam logic [1:0] RX_SHORT   = 2'd1;
   localparam logic [1:0] RX_DROPPED = 2'd2;

   // frames below this length are not captured
   localparam logic [11:0] MIN_FRAME_LEN = 12'd24;

   // 802.11 frame control: type in bits 3..2, subtype in bits 7..4
   localparam int FC_KIND_LSB    = 2;
   localparam int FC_SUBKIND_LSB = 4;
   localparam logic [1:0] KIND_MASK    = 2'h3;
   localparam logic [3:0] SUBKIND_MASK = 4'hF;

   localparam int ENTRY_W = 62;

   // stored metadata, timestamp in the low bits
   typedef struct packed {
      logic [3:0]  subkind;
      logic [1:0]  kind;
      logic [11:0] length;
      logic [3:0]  channel;
      logic [7:0]  strength;
      logic [31:0] time_ms;
   } entry_type;

   // what the queue controller decided for one accepted request
   typedef struct packed {
      logic        push;
      logic        pop;
      logic [1:0]  rx_status;
      logic [31:0] dropped_total;
      logic [31:0] captured_total;
   } action_type;

   // first pipeline stage, waiting for the entry read
   typedef struct packed {
      logic [1:0]  rx_status;
      logic        pop_valid;
      logic [31:0] dropped_total;
      logic [31:0] captured_total;
   } stage_type;

endpackage

[src/fmcq_ram.sv]
// ----------------------------------------------------------------------------
// fmcq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmcq_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fmcq_ctrl.sv]
// ----------------------------------------------------------------------------
// fmcq_ctrl: queue pointers, fill level and event counters
// Decides push, drop or pop for each accepted request and updates state.
// ----------------------------------------------------------------------------
module fmcq_ctrl #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                req_type,
   input  logic [11:0]                         signal_length,
   output fmcq_pkg::action_type                action,
   output logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
   output logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    fill_level
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       drop_ff, drop_in;
   logic [31:0]       capture_ff, capture_in;

   logic is_rx, too_short, full, empty;
   logic push, drop, pop;

   always_comb begin
      is_rx     = (req_type == fmcq_pkg::REQ_RX);
      too_short = (signal_length < fmcq_pkg::MIN_FRAME_LEN);
      full      = (fill_ff == FULL_FILL);
      empty     = (fill_ff == '0);

      push = accept && is_rx && !too_short && !full;
      drop = accept && is_rx && !too_short && full;
      pop  = accept && !is_rx && !empty;

      // advance pointers with wrap at the queue depth
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end

      fill_in = fill_ff;
      if (push) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop) begin
         fill_in = fill_ff - 1'b1;
      end

      drop_in    = drop ? drop_ff + 32'd1 : drop_ff;
      capture_in = push ? capture_ff + 32'd1 : capture_ff;

      action.push = push;
      action.pop  = pop;
      if (!is_rx) begin
         action.rx_status = fmcq_pkg::RX_STORED;
      end else if (too_short) begin
         action.rx_status = fmcq_pkg::RX_SHORT;
      end else if (full) begin
         action.rx_status = fmcq_pkg::RX_DROPPED;
      end else begin
         action.rx_status = fmcq_pkg::RX_STORED;
      end
      action.dropped_total  = drop_in;
      action.captured_total = capture_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         drop_ff    <= '0;
         capture_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
         drop_ff    <= drop_in;
         capture_ff <= capture_in;
      end
   end

   assign wr_addr    = wr_ptr_ff;
   assign rd_addr    = rd_ptr_ff;
   assign fill_level = fill_ff;

endmodule

[src/frame_metadata_capture_queue.sv]
// ----------------------------------------------------------------------------
// frame_metadata_capture_queue: ring queue of received-frame metadata
// Captures frame events of at least 24 bytes, counts drops when full, and
// returns the oldest entry on a pop request, one response per request.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+--------------------------------
//   req     | in  | req_tvalid / req_tready   | tuser: request type, tdata: frame
//   rsp     | out | rsp_tvalid / rsp_tready   | tuser: status, tdata: entry+totals
//
// Flow: one request accepted per cycle while req_tready is high; at the
//   accepting edge the controller decision and entry RAM read register, then
//   the response register loads once the read stage can advance. The
//   registered RAM read port is why the read stage exists.
// Reset: synchronous, active high; clears pointers, fill level, both counters
//   and the pipeline valids. Entry RAM contents are not cleared.
// Stalls: req_tready drops only while both the read stage and the response
//   register are full and rsp_tready is low.
//
module frame_metadata_capture_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,    // [0] req_type
   input  logic [71:0]  req_tdata,    // [15:0] frame_control, [27:16] signal_length,
                                      // [35:28] signal_strength, [39:36] radio_channel,
                                      // [71:40] time_ms
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,    // [1:0] rx_status, [2] pop_valid
   output logic [127:0] rsp_tdata     // [31:0] out_time_ms, [39:32] out_strength,
                                      // [43:40] out_channel, [55:44] out_length,
                                      // [57:56] out_frame_kind,
                                      // [61:58] out_frame_subkind,
                                      // [93:62] dropped_total,
                                      // [125:94] captured_total, [127:126] zero
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   // unpack the request
   logic [15:0] frame_control;
   logic [11:0] signal_length;
   logic [7:0]  signal_strength;
   logic [3:0]  radio_channel;
   logic [31:0] time_ms;

   assign frame_control   = req_tdata[15:0];
   assign signal_length   = req_tdata[27:16];
   assign signal_strength = req_tdata[35:28];
   assign radio_channel   = req_tdata[39:36];
   assign time_ms         = req_tdata[71:40];

   logic                 req_accept;
   fmcq_pkg::action_type action;
   logic [PTR_W-1:0]     wr_addr, rd_addr;
   logic [FILL_W-1:0]    fill_level;
   fmcq_pkg::entry_type  wr_entry, rd_entry;
   logic [fmcq_pkg::ENTRY_W-1:0] rd_data;

   fmcq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req_type     (req_tuser),
      .signal_length(signal_length),
      .action       (action),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .fill_level   (fill_level)
   );

   // build the entry: type and subtype come from the frame control word
   always_comb begin
      wr_entry.time_ms  = time_ms;
      wr_entry.strength = signal_strength;
      wr_entry.channel  = radio_channel;
      wr_entry.length   = signal_length;
      wr_entry.kind     = frame_control[fmcq_pkg::FC_KIND_LSB +: 2] & fmcq_pkg::KIND_MASK;
      wr_entry.subkind  = frame_control[fmcq_pkg::FC_SUBKIND_LSB +: 4]
                          & fmcq_pkg::SUBKIND_MASK;
   end

   // read data only changes on a pop, so it holds while the read stage stalls
   fmcq_ram #(
      .WIDTH(fmcq_pkg::ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (action.push),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (action.pop),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry = rd_data;

   // read stage: hold status and totals while the entry read completes
   logic                s1_valid_ff, s1_valid_in;
   fmcq_pkg::stage_type s1_ff;
   logic                s1_advance;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic                rsp_pop_ff;
   fmcq_pkg::entry_type rsp_entry_ff;
   logic [31:0]         rsp_dropped_ff;
   logic [31:0]         rsp_captured_ff;

   always_comb begin
      s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready   = !s1_valid_ff || s1_advance;
      req_accept   = req_tvalid && req_tready;
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the read stage on each accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.rx_status      <= action.rx_status;
         s1_ff.pop_valid      <= action.pop;
         s1_ff.dropped_total  <= action.dropped_total;
         s1_ff.captured_total <= action.captured_total;
      end
   end

   // advance into the response register; zero the entry unless a pop hit
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_status_ff   <= s1_ff.rx_status;
         rsp_pop_ff      <= s1_ff.pop_valid;
         rsp_entry_ff    <= s1_ff.pop_valid ? rd_entry : '0;
         rsp_dropped_ff  <= s1_ff.dropped_total;
         rsp_captured_ff <= s1_ff.captured_total;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_pop_ff, rsp_status_ff};
   assign rsp_tdata  = {2'b00, rsp_captured_ff, rsp_dropped_ff, rsp_entry_ff};

`ifndef SYNTHESIS
   // a request either pushes or pops, never both
   assert property (@(posedge clock) disable iff (reset)
      !(action.push && action.pop))
      else $error("push and pop in the same cycle");

   // fill level never passes the queue depth
   assert property (@(posedge clock) disable iff (reset)
      fill_level <= FILL_W'(QUEUE_DEPTH))
      else $error("fill level above queue depth");

   // a successful pop lands in the read stage marked valid
   assert property (@(posedge clock) disable iff (reset)
      action.pop |=> (s1_valid_ff && s1_ff.pop_valid))
      else $error("pop lost before read stage");

   // a stalled read stage keeps its request
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("read stage changed while stalled");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the frame metadata capture queue
// Streams frame events and pop requests into the queue, tracks the ring of
// captured metadata and both totals alongside the block, and checks every
// response field against the tracked state, in order, under varying
// backpressure.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUEUE_DEPTH      = 16;
   localparam int RANDOM_PER_PHASE = 542;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 120;

   // one frame event or pop request waiting to be driven
   typedef struct {
      logic        req_type;
      logic [15:0] frame_control;
      logic [11:0] length;
      logic [7:0]  strength;
      logic [3:0]  channel;
      logic [31:0] time_ms;
      bit          wait_drain;   // hold this request until all responses are in
   } frame_request_type;

   // the response the queue owes for one accepted request
   typedef struct {
      logic [1:0]          rx_status;
      logic                pop_valid;
      fmcq_pkg::entry_type entry;
      logic [31:0]         dropped_total;
      logic [31:0]         captured_total;
   } queue_response_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser  = fmcq_pkg::REQ_RX;  // [0] req_type
   logic [71:0]  req_tdata  = '0;      // [15:0] frame_control, [27:16] signal_length,
                                       // [35:28] signal_strength, [39:36] radio_channel,
                                       // [71:40] time_ms
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [2:0]   rsp_tuser;            // [1:0] rx_status, [2] pop_valid
   logic [127:0] rsp_tdata;            // [61:0] entry, [93:62] dropped_total,
                                       // [125:94] captured_total, [127:126] zero

   // stimulus and expectations
   frame_request_type  frame_requests[$];
   queue_response_type awaited_responses[$];

   // tracked queue state
   fmcq_pkg::entry_type captured_entries [QUEUE_DEPTH];
   int                  head_index;
   int                  tail_index;
   int                  entry_count;
   logic [31:0]         drop_total;
   logic [31:0]         capture_total;

   // run control and statistics
   int idle_phase    = 0;
   bit long_hold_due = 1'b0;
   int mismatch_count;
   int requests_accepted;
   int responses_checked;
   int short_frames;
   int pops_with_entry;
   int pops_on_empty;

   frame_metadata_capture_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idling mix: receiver sparse first, then sender sparse, then full rate
   function automatic int sender_idle_pct();
      case (idle_phase)
         0: return 25;
         1: return 86;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_phase)
         0: return 86;
         1: return 25;
         default: return 0;
      endcase
   endfunction

   // Advance the tracked queue by one accepted request and record the
   // response it must produce.
   function automatic void predict_queue_response(input logic kind_sel,
                                                  input logic [71:0] data);
      queue_response_type  rsp;
      fmcq_pkg::entry_type fresh;
      logic [15:0]         fc;
      logic [11:0]         len;

      fc  = data[15:0];
      len = data[27:16];
      rsp = '{default: '0};
      if (kind_sel == fmcq_pkg::REQ_RX) begin
         if (len < fmcq_pkg::MIN_FRAME_LEN) begin
            // too short: nothing moves
            rsp.rx_status = fmcq_pkg::RX_SHORT;
            short_frames++;
         end else if (entry_count == QUEUE_DEPTH) begin
            drop_total++;
            rsp.rx_status = fmcq_pkg::RX_DROPPED;
         end else begin
            fresh.time_ms  = data[71:40];
            fresh.channel  = data[39:36];
            fresh.strength = data[35:28];
            fresh.length   = len;
            fresh.kind     = fc[fmcq_pkg::FC_KIND_LSB +: 2] & fmcq_pkg::KIND_MASK;
            fresh.subkind  = fc[fmcq_pkg::FC_SUBKIND_LSB +: 4] & fmcq_pkg::SUBKIND_MASK;
            captured_entries[tail_index] = fresh;
            tail_index = (tail_index + 1) % QUEUE_DEPTH;
            entry_count++;
            capture_total++;
            rsp.rx_status = fmcq_pkg::RX_STORED;
         end
      end else if (entry_count != 0) begin
         rsp.pop_valid = 1'b1;
         rsp.entry     = captured_entries[head_index];
         head_index    = (head_index + 1) % QUEUE_DEPTH;
         entry_count--;
         pops_with_entry++;
      end else begin
         // empty pop: zero entry, state untouched
         pops_on_empty++;
      end
      rsp.dropped_total  = drop_total;
      rsp.captured_total = capture_total;
      awaited_responses.push_back(rsp);
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_response();
      queue_response_type  want;
      fmcq_pkg::entry_type got;

      if (awaited_responses.size() == 0) begin
         $display("%0t: response with none expected, expected nothing, actual %s %0h %0h",
                  $time, "tuser/tdata", rsp_tuser, rsp_tdata);
         mismatch_count++;
         return;
      end
      want = awaited_responses.pop_front();
      got  = rsp_tdata[61:0];
      compare_field("rx_status",         32'(want.rx_status),      32'(rsp_tuser[1:0]));
      compare_field("pop_valid",         32'(want.pop_valid),      32'(rsp_tuser[2]));
      compare_field("out_time_ms",       want.entry.time_ms,       got.time_ms);
      compare_field("out_strength",      32'(want.entry.strength), 32'(got.strength));
      compare_field("out_channel",       32'(want.entry.channel),  32'(got.channel));
      compare_field("out_length",        32'(want.entry.length),   32'(got.length));
      compare_field("out_frame_kind",    32'(want.entry.kind),     32'(got.kind));
      compare_field("out_frame_subkind", 32'(want.entry.subkind),  32'(got.subkind));
      compare_field("dropped_total",     want.dropped_total,       rsp_tdata[93:62]);
      compare_field("captured_total",    want.captured_total,      rsp_tdata[125:94]);
      compare_field("tdata padding",     '0,                       32'(rsp_tdata[127:126]));
      responses_checked++;
   endtask

   task automatic add_request(input logic req_type, input logic [15:0] fc,
                              input logic [11:0] len, input logic [7:0] strength,
                              input logic [3:0] channel, input logic [31:0] time_ms);
      frame_request_type r;
      r.req_type      = req_type;
      r.frame_control = fc;
      r.length        = len;
      r.strength      = strength;
      r.channel       = channel;
      r.time_ms       = time_ms;
      r.wait_drain    = 1'b0;
      frame_requests.push_back(r);
   endtask

   // Walk the corner cases: empty pop, short frames at both ends, a full
   // ring with every kind/subkind and field extreme, a drop, a short frame
   // while full, and a store after the write side wraps.
   task automatic queue_directed_requests();
      logic [15:0] fc;
      logic [11:0] len;
      logic [7:0]  strength;
      logic [31:0] stamp;

      add_request(fmcq_pkg::REQ_POP, 16'hFFFF, 12'hFFF, 8'hFF, 4'hF, 32'hFFFF_FFFF);
      add_request(fmcq_pkg::REQ_RX,  16'h00FC, 12'd0,   8'h00, 4'h0, 32'h0000_0000);
      add_request(fmcq_pkg::REQ_RX,  16'hFFFF, fmcq_pkg::MIN_FRAME_LEN - 12'd1, 8'h80, 4'hF,
                  32'hFFFF_FFFF);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         fc       = {8'hA5 ^ 8'(i * 17), 4'(i), 2'(i), 2'(i + 1)};
         len      = (i == 0) ? fmcq_pkg::MIN_FRAME_LEN : (i == 1) ? 12'hFFF : 12'(24 + i * 200);
         strength = (i == 0) ? 8'h80 : (i == 1) ? 8'h7F : 8'(i * 13);
         stamp    = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
         add_request(fmcq_pkg::REQ_RX, fc, len, strength, 4'(i), stamp);
      end
      add_request(fmcq_pkg::REQ_RX,  16'hFFFF, fmcq_pkg::MIN_FRAME_LEN, 8'h7F, 4'hF,
                  32'h1234_5678);
      add_request(fmcq_pkg::REQ_RX,  16'h0000, 12'd23,  8'h80, 4'h0, 32'h8765_4321);
      add_request(fmcq_pkg::REQ_POP, 16'h0000, 12'h000, 8'h00, 4'h0, 32'h0);
      add_request(fmcq_pkg::REQ_POP, 16'hFFFF, 12'hFFF, 8'hFF, 4'hF, 32'hFFFF_FFFF);
      add_request(fmcq_pkg::REQ_RX,  16'h00F0, 12'd100, 8'hC0, 4'h9, 32'hDEAD_BEEF);
   endtask

   // Random traffic in bursts whose push share swings the fill level between
   // empty and full; one request per phase waits until every response is in.
   task automatic queue_random_requests(input int count);
      frame_request_type r;
      int                push_pct;

      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 90;
            endcase
         end
         r.req_type      = ($urandom_range(99) < push_pct) ? fmcq_pkg::REQ_RX
                                                           : fmcq_pkg::REQ_POP;
         r.frame_control = 16'($urandom);
         r.strength      = 8'($urandom);
         r.channel       = 4'($urandom);
         r.time_ms       = $urandom;
         case ($urandom_range(9))
            0: r.length = 12'($urandom_range(23));
            1: r.length = $urandom_range(1) ? 12'hFFF : fmcq_pkg::MIN_FRAME_LEN;
            default: r.length = 12'($urandom_range(24, 4095));
         endcase
         r.wait_drain = (i == count / 2);
         frame_requests.push_back(r);
      end
   endtask

   // Request driver: predict on acceptance, then offer the next request when
   // the slot is free and the sender is not idling.
   always @(posedge clock) begin : request_driver
      logic              offer;
      frame_request_type nxt;

      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_queue_response(req_tuser, req_tdata);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            offer = frame_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct();
            // hold a drain request back until every response is in
            if (offer && frame_requests[0].wait_drain && awaited_responses.size() != 0)
               offer = 1'b0;
            if (offer) begin
               nxt = frame_requests.pop_front();
               req_tuser <= nxt.req_type;
               req_tdata <= {nxt.time_ms, nxt.channel, nxt.strength, nxt.length,
                             nxt.frame_control};
            end
            req_tvalid <= offer;
         end
      end
   end

   // Response monitor: check each accepted response, then pick tready, with
   // one long hold-off so the pipeline fills and stalls the request side.
   always @(posedge clock) begin : response_monitor
      int hold_left;
      bit long_hold_done;

      if (reset) begin
         rsp_tready     <= 1'b0;
         hold_left      = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response();
         if (long_hold_due && !long_hold_done) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= receiver_idle_pct();
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin : stall_watchdog
      int quiet_cycles;

      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or response accepted for %0d cycles",
                     $time, quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      head_index    = 0;
      tail_index    = 0;
      entry_count   = 0;
      drop_total    = '0;
      capture_total = '0;

      // hold reset, then release it on a rising edge
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // load stimulus on falling edges so the driver sees a settled queue
      @(negedge clock);
      queue_directed_requests();
      for (int phase = 0; phase < 3; phase++) begin
         idle_phase = phase;
         if (phase == 2)
            long_hold_due = 1'b1;
         queue_random_requests(RANDOM_PER_PHASE);
         while (frame_requests.size() != 0 || req_tvalid || awaited_responses.size() != 0)
            @(negedge clock);
      end

      // allow the two-stage pipeline to flush anything unexpected
      repeat (5) @(posedge clock);

      $display("covered %0d requests: %0d frames captured, %0d too short, %0d dropped",
               requests_accepted, capture_total, short_frames, drop_total);
      $display("checked %0d responses: %0d pops returned entries, %0d found it empty",
               responses_checked, pops_with_entry, pops_on_empty);
      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
src/fmcq_pkg.sv
src/fmcq_ram.sv
src/fmcq_ctrl.sv
src/frame_metadata_capture_queue.sv
dv/tb.sv
